// ----- hw/rtl/ilir_pkg.sv -----
`timescale 1ns / 1ps
// Package for the indexed list insert/remove block.
// Holds sizes, command and status codes, and the cell control type; no dependencies.
package ilir_pkg;

  // List capacity and derived widths
  localparam int DEPTH   = 16;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W   = 8;
  localparam int CMP_W   = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;
  localparam int WORD_W  = 32;

  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [CMP_W-1:0]     cmp_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [4:0]           count_field_t;

  // Command codes carried on the cmd field
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Per-cell action for one transaction
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LOWER = 2'd2,
    CELL_FROM_UPPER = 2'd3
  } cell_mode_t;

endpackage

// ----- hw/rtl/ilir_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the indexed list block.
// Depends on ilir_pkg for field types.
interface ilir_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  ilir_pkg::idx_t     index;
  ilir_pkg::word_t    value;

  modport source (output valid, output cmd, output index, output value, input ready);
  modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

interface ilir_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  ilir_pkg::count_field_t   count_after;
  ilir_pkg::word_t          read_word;

  modport source (output valid, output status, output count_after, output read_word,
                  input ready);
  modport sink   (input valid, input status, input count_after, input read_word,
                  output ready);
endinterface

// ----- hw/rtl/ilir_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the list: holds a word and takes a new one from the
// command value or a neighbor. Depends on ilir_pkg.
module ilir_cell (
  input  logic                  clk,
  input  ilir_pkg::cell_mode_t  mode,
  input  ilir_pkg::word_t       value,
  input  ilir_pkg::word_t       lower,
  input  ilir_pkg::word_t       upper,
  output ilir_pkg::word_t       word
);

  ilir_pkg::word_t word_next;

  // Pick the source for this cycle
  always_comb begin
    case (mode)
      ilir_pkg::CELL_HOLD:       word_next = word;
      ilir_pkg::CELL_LOAD:       word_next = value;
      ilir_pkg::CELL_FROM_LOWER: word_next = lower;
      ilir_pkg::CELL_FROM_UPPER: word_next = upper;
      default:                   word_next = word;
    endcase
  end

  // Store the word; payload needs no reset
  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ----- hw/rtl/indexed_list_insert_remove.sv -----
`timescale 1ns / 1ps
// Top level of the indexed list: a row of shifting cells plus count and result register.
// Depends on ilir_pkg, ilir_if and ilir_cell.

// Ordered list of up to DEPTH (16) signed 32-bit words held in a row of register
// cells. Each input transaction is an insert, remove or read at an index; every
// transaction gives exactly one result with a status, the count after it and, for a
// read, the word. A command finishes in the cycle it is accepted: all cells shift in
// parallel toward or away from the position; one transaction per clock if unstalled.
// The result sits in an output register, and a new transaction is accepted whenever
// that register is empty or being drained in the same cycle. Insert past the count
// appends; insert into a full list returns status 1; remove or read at or beyond the
// count returns status 2. No clearing pass is needed after reset.
module indexed_list_insert_remove (
  input  logic             clk,
  input  logic             rst,
  ilir_in_if.sink          in_ch,
  ilir_out_if.source       out_ch
);

  localparam int DEPTH = ilir_pkg::DEPTH;

  ilir_pkg::count_t      count;
  ilir_pkg::count_t      count_next;
  logic                  in_fire;
  logic                  ins_ok;
  logic                  rem_ok;
  logic                  rd_ok;
  ilir_pkg::cmp_t        idx_ext;
  ilir_pkg::cmp_t        cnt_ext;
  ilir_pkg::cmp_t        pos;
  ilir_pkg::word_t       cell_word [DEPTH];
  ilir_pkg::cell_mode_t  cell_mode [DEPTH];
  ilir_pkg::status_t     status_next;
  ilir_pkg::word_t       read_next;

  logic                  out_valid;
  ilir_pkg::status_t     status;
  ilir_pkg::count_field_t count_after;
  ilir_pkg::word_t       read_word;

  // Accept while the result register is free or draining
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Decode the command against the current count
  assign idx_ext = ilir_pkg::cmp_t'(in_ch.index);
  assign cnt_ext = ilir_pkg::cmp_t'(count);
  assign ins_ok  = (in_ch.cmd == ilir_pkg::CMD_INSERT) &&
                   (cnt_ext < ilir_pkg::cmp_t'(DEPTH));
  assign rem_ok  = (in_ch.cmd == ilir_pkg::CMD_REMOVE) && (idx_ext < cnt_ext);
  assign rd_ok   = (in_ch.cmd == ilir_pkg::CMD_READ) && (idx_ext < cnt_ext);
  assign pos     = (idx_ext > cnt_ext) ? cnt_ext : idx_ext;

  // Per-cell action and the row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      cell_mode[i] = ilir_pkg::CELL_HOLD;
      if (in_fire && ins_ok) begin
        if (ilir_pkg::cmp_t'(i) == pos) begin
          cell_mode[i] = ilir_pkg::CELL_LOAD;
        end else if (ilir_pkg::cmp_t'(i) > pos) begin
          cell_mode[i] = ilir_pkg::CELL_FROM_LOWER;
        end
      end else if (in_fire && rem_ok) begin
        if (ilir_pkg::cmp_t'(i) >= idx_ext) begin
          cell_mode[i] = ilir_pkg::CELL_FROM_UPPER;
        end
      end
    end

    ilir_cell u_cell (
      .clk   (clk),
      .mode  (cell_mode[i]),
      .value (in_ch.value),
      .lower (cell_word[(i > 0) ? i - 1 : 0]),
      .upper (cell_word[(i < DEPTH - 1) ? i + 1 : DEPTH - 1]),
      .word  (cell_word[i])
    );
  end

  // Status, read word and next count
  always_comb begin
    status_next = ilir_pkg::ST_RANGE;
    read_next   = '0;
    count_next  = count;
    case (in_ch.cmd)
      ilir_pkg::CMD_INSERT: begin
        if (ins_ok) begin
          status_next = ilir_pkg::ST_DONE;
          count_next  = count + ilir_pkg::count_t'(1);
        end else begin
          status_next = ilir_pkg::ST_FULL;
        end
      end
      ilir_pkg::CMD_REMOVE: begin
        if (rem_ok) begin
          status_next = ilir_pkg::ST_DONE;
          count_next  = count - ilir_pkg::count_t'(1);
        end
      end
      ilir_pkg::CMD_READ: begin
        if (rd_ok) begin
          status_next = ilir_pkg::ST_DONE;
          read_next   = cell_word[in_ch.index[ilir_pkg::ADDR_W-1:0]];
        end
      end
      default: begin
        status_next = ilir_pkg::ST_RANGE;
      end
    endcase
  end

  // Advance the count on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_fire) begin
      count <= count_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status      <= status_next;
      count_after <= ilir_pkg::count_field_t'(count_next);
      read_word   <= read_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = status;
  assign out_ch.count_after = count_after;
  assign out_ch.read_word   = read_word;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for indexed_list_insert_remove: directed table, then random commands.
// Depends on ilir_pkg, ilir_if and the block's RTL; self-checking, no external files.
module tb;
  import ilir_pkg::*;

  // cmd value outside the command set
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 450;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    status_t      status;
    count_field_t count;
    word_t        word;
  } list_result_t;

  typedef struct packed {
    logic [1:0]   cmd;
    idx_t         index;
    word_t        value;
    bit           typed;
    list_result_t res;
  } stim_row_t;

  logic clk;
  logic rst;

  ilir_in_if  in_ch ();
  ilir_out_if out_ch ();

  indexed_list_insert_remove i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Mirror of the list contents and length
  word_t  list_mem [DEPTH];
  count_t list_len;

  list_result_t expect_q [$];
  stim_row_t    directed_q [$];

  // Typed expectation travels with the transaction on the input side
  bit           drv_typed;
  list_result_t drv_res;

  int err_cnt;
  int checked_cnt;
  int idle_cycles;
  int n_cmd [4];
  int n_full;
  int n_range;
  int peak_len;
  list_result_t predicted;
  list_result_t oldest;

  logic [6:0] ready_age;
  logic [1:0] ready_mode;
  logic [7:0] ready_pat;

  int burst_left;

  // Apply one command to the mirror and return its result
  function automatic list_result_t apply_cmd(input logic [1:0] cmd, input idx_t idx,
                                             input word_t val);
    list_result_t r;
    int pos;
    r.status = ST_RANGE;
    r.word   = '0;
    case (cmd)
      CMD_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = (idx > list_len) ? int'(list_len) : int'(idx);
          for (int i = int'(list_len); i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
          r.status = ST_DONE;
        end
      end
      CMD_REMOVE: begin
        if (idx < list_len) begin
          for (int i = int'(idx); i + 1 < int'(list_len); i++) list_mem[i] = list_mem[i+1];
          list_len--;
          r.status = ST_DONE;
        end
      end
      CMD_READ: begin
        if (idx < list_len) begin
          r.word   = list_mem[idx];
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    r.count = count_field_t'(list_len);
    return r;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input idx_t idx, input word_t val,
                         input bit typed, input status_t st, input int cnt, input word_t w);
    stim_row_t row;
    row.cmd        = cmd;
    row.index      = idx;
    row.value      = val;
    row.typed      = typed;
    row.res.status = st;
    row.res.count  = count_field_t'(cnt);
    row.res.word   = w;
    directed_q.push_back(row);
  endtask

  // Present one transaction and hold it until accepted; insert gaps between bursts
  task automatic send(input stim_row_t row);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= row.cmd;
    in_ch.index <= row.index;
    in_ch.value <= row.value;
    drv_typed   <= row.typed;
    drv_res     <= row.res;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall pattern changes mode whenever the 7-bit ready_age counter wraps
  always @(posedge clk) begin
    ready_age <= ready_age + 7'd1;
    if (ready_age == 7'd0) begin
      ready_mode <= 2'($urandom_range(0, 3));
      ready_pat  <= 8'($urandom);
    end else begin
      ready_pat <= {ready_pat[6:0], ready_pat[7]};
    end
    case (ready_mode)
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= 1'($urandom_range(0, 1));
      2'd2:    out_ch.ready <= ready_pat[0];
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Predict on input transactions, check output transactions, watch for hangs
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted = apply_cmd(in_ch.cmd, in_ch.index, in_ch.value);
        expect_q.push_back(drv_typed ? drv_res : predicted);
        n_cmd[in_ch.cmd]++;
        if (predicted.status == ST_FULL) n_full++;
        if (predicted.status == ST_RANGE) n_range++;
        if (int'(list_len) > peak_len) peak_len = int'(list_len);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expect_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d count=%0d word=%0d", $time,
                   out_ch.status, out_ch.count_after, out_ch.read_word);
          err_cnt++;
        end else begin
          oldest = expect_q.pop_front();
          checked_cnt++;
          if (out_ch.status !== oldest.status) begin
            $display("%0t: status expected %0d, got %0d", $time, oldest.status,
                     out_ch.status);
            err_cnt++;
          end
          if (out_ch.count_after !== oldest.count) begin
            $display("%0t: count_after expected %0d, got %0d", $time, oldest.count,
                     out_ch.count_after);
            err_cnt++;
          end
          if (out_ch.read_word !== oldest.word) begin
            $display("%0t: read_word expected %0d, got %0d", $time, oldest.word,
                     out_ch.read_word);
            err_cnt++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    stim_row_t row;
    int pick;
    int phase;
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_INSERT;
    in_ch.index  = '0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    drv_typed    = 1'b0;
    drv_res      = '0;
    ready_age    = '0;
    ready_mode   = 2'd0;
    ready_pat    = 8'hFF;
    list_len     = '0;
    err_cnt      = 0;
    checked_cnt  = 0;
    idle_cycles  = 0;
    n_cmd        = '{default: 0};
    n_full       = 0;
    n_range      = 0;
    peak_len     = 0;
    burst_left   = 0;

    // Empty list, then extremes of index and value
    add_row(CMD_READ,    8'd0,   32'sd0,  1, ST_RANGE, 0, 32'sd0);
    add_row(CMD_REMOVE,  8'd0,   32'sd0,  1, ST_RANGE, 0, 32'sd0);
    add_row(CMD_UNKNOWN, 8'd0,   WORD_MAX, 1, ST_RANGE, 0, 32'sd0);
    add_row(CMD_INSERT,  8'd255, WORD_MAX, 1, ST_DONE,  1, 32'sd0);
    add_row(CMD_INSERT,  8'd0,   WORD_MIN, 1, ST_DONE,  2, 32'sd0);
    add_row(CMD_READ,    8'd0,   32'sd0,  1, ST_DONE,  2, WORD_MIN);
    add_row(CMD_READ,    8'd1,   32'sd0,  1, ST_DONE,  2, WORD_MAX);
    add_row(CMD_REMOVE,  8'd2,   32'sd0,  1, ST_RANGE, 2, 32'sd0);
    add_row(CMD_READ,    8'd255, 32'sd0,  1, ST_RANGE, 2, 32'sd0);
    // Fill to capacity at scattered positions
    add_row(CMD_INSERT, 8'd1,   32'sh0000_0001, 0, ST_DONE, 0, 32'sd0);
    add_row(CMD_INSERT, 8'd3,   32'shFFFF_FFFF, 0, ST_DONE, 0, 32'sd0);
    add_row(CMD_INSERT, 8'd0,   32'sh0000_0000, 0, ST_DONE, 0, 32'sd0);
    add_row(CMD_INSERT, 8'd255, 32'sh5555_5555, 0, ST_DONE, 0, 32'sd0);
    add_row(CMD_INSERT, 8'd8,   32'shAAAA_AAAA, 0, ST_DONE, 0, 32'sd0);
    add_row(CMD_INSERT, 8'd2,   32'sh0000_FFFF, 0, ST_DONE, 0, 32'sd0);
    add_row(CMD_INSERT, 8'd5,   32'shFFFF_0000, 0, ST_DONE, 0, 32'sd0);
    add_row(CMD_INSERT, 8'd16,  32'sh1234_5678, 0, ST_DONE, 0, 32'sd0);
    add_row(CMD_INSERT, 8'd7,   32'sh8000_0001, 0, ST_DONE, 0, 32'sd0);
    add_row(CMD_INSERT, 8'd0,   32'sh7FFF_FFFE, 0, ST_DONE, 0, 32'sd0);
    add_row(CMD_INSERT, 8'd12,  32'sh0F0F_0F0F, 0, ST_DONE, 0, 32'sd0);
    add_row(CMD_INSERT, 8'd4,   32'shF0F0_F0F0, 0, ST_DONE, 0, 32'sd0);
    add_row(CMD_INSERT, 8'd9,   32'sh3333_CCCC, 0, ST_DONE, 0, 32'sd0);
    add_row(CMD_INSERT, 8'd200, 32'shCCCC_3333, 0, ST_DONE, 0, 32'sd0);
    // Full list refuses; remove at both ends
    add_row(CMD_INSERT, 8'd7,   32'sd1,   1, ST_FULL, 16, 32'sd0);
    add_row(CMD_REMOVE, 8'd15,  32'sd0,   1, ST_DONE, 15, 32'sd0);
    add_row(CMD_REMOVE, 8'd0,   32'sd0,   1, ST_DONE, 14, 32'sd0);
    add_row(CMD_READ,   8'd13,  32'sd0,   0, ST_DONE, 0,  32'sd0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_q[i]) send(directed_q[i]);

    // Random commands in phases that fill, drain and mix the list
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / 50) % 3;
      pick  = $urandom_range(0, 99);
      if (pick < ((phase == 0) ? 60 : (phase == 1) ? 20 : 40)) row.cmd = CMD_INSERT;
      else if (pick < 75) row.cmd = CMD_REMOVE;
      else if (pick < 95) row.cmd = CMD_READ;
      else row.cmd = CMD_UNKNOWN;
      row.index = ($urandom_range(0, 9) == 0) ? idx_t'($urandom_range(0, 255))
                                              : idx_t'($urandom_range(0, 17));
      case ($urandom_range(0, 7))
        0:       row.value = WORD_MAX;
        1:       row.value = WORD_MIN;
        2:       row.value = 32'sd0;
        3:       row.value = -32'sd1;
        default: row.value = word_t'($urandom);
      endcase
      row.typed = 1'b0;
      row.res   = '0;
      send(row);
    end

    // Drain outstanding results, then let the pipeline settle
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d inserts, %0d removes, %0d reads, %0d unknown commands",
             n_cmd[CMD_INSERT], n_cmd[CMD_REMOVE], n_cmd[CMD_READ], n_cmd[CMD_UNKNOWN]);
    $display("%0d results checked, %0d full refusals, %0d range errors, peak length %0d",
             checked_cnt, n_full, n_range, peak_len);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
